>>> rtl/core/ptrt_pkg.sv
`default_nettype none

package ptrt_pkg;

    // number of timing register slots and the widths of the packed fields
    localparam int unsigned SLOT_COUNT = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned TIMING_W   = 48;
    localparam int unsigned TICK_W     = 32;
    localparam int unsigned COUNT_W    = 17;
    localparam int unsigned FIELD_W    = 16;
    localparam int unsigned MASK_W     = 8;

    // item kinds
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // timing register values after reset, offset zero for all tasks
    localparam logic [TIMING_W-1:0] TIMING_RESET [SLOT_COUNT] = '{
        48'd65538,    48'd327690,   48'd655380,   48'd1638450,
        48'd32768500, 48'd32769000, 48'd65538000, 48'd655380000
    };

    typedef struct packed {
        logic       func;
        logic [3:0] task_id;
    } t_in_item;

    typedef struct packed {
        logic              granted;
        logic [MASK_W-1:0] pending_mask;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the input item, bump the tick count for a tick item
        logic step;     // advance one task counter
        logic query;    // evaluate the query
        logic publish;  // move the result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_slot;  // current counter slot is the last task
        logic out_free;   // output register can take a result this cycle
    } t_status;

endpackage

`default_nettype wire

>>> rtl/core/periodic_task_release_timer.sv
`default_nettype none

// Release timer for up to NUM_TASKS periodic tasks. A tick item (func 0) bumps the
// 32-bit tick count and walks the task counters one task per cycle; a query item
// (func 1) asks for a grant on one task. The walk over the counters is the only
// loop over the tasks in the sequencer. One item is worked at a time; a finished
// result sits in the output register while the next item is accepted, and a new
// result waits in the finish state only if the previous one has not been taken.
// Every item gives exactly one result: granted plus the pending mask after the
// item. Timing registers (index 0 to 7, period 15:0, minimum interval 31:16,
// offset 47:32) are to be written through the plain write port only while the
// block is idle; the block itself does not enforce this. Writes to tasks at or
// beyond NUM_TASKS are dropped.
module periodic_task_release_timer #(
    parameter int unsigned NUM_TASKS = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire ptrt_pkg::t_in_item               i_in,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output ptrt_pkg::t_out_item                   o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [ptrt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ptrt_pkg::TIMING_W-1:0]    i_cfg_data
);

    ptrt_pkg::t_cmd    w_cmd;
    ptrt_pkg::t_status w_status;
    logic              w_busy;

    // sequencer
    ptrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_func  (i_in.func),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    // timing registers, task state and output register
    ptrt_dp #(
        .NUM_TASKS (NUM_TASKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    assign o_in_stall = w_busy;

    // an accepted item always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> w_busy)
        else $error("accepted item did not start work");

    // a new result only appears after the sequencer publishes it
    a_result_from_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.publish))
        else $error("result appeared without publish");

    // tasks beyond the configured count never show as pending
    a_mask_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((16'(o_out.pending_mask) >> NUM_TASKS) == 16'd0))
        else $error("pending bit set for an absent task");

    // publishing never overwrites a result that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.publish |-> (!o_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

>>> rtl/core/ptrt_ctrl.sv
`default_nettype none

module ptrt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_func,
    input  wire ptrt_pkg::t_status i_status,
    output ptrt_pkg::t_cmd        o_cmd,
    output logic                  o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_QUERY,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_in_func == ptrt_pkg::FUNC_TICK) ? S_TICK : S_QUERY;
                end
            end
            S_TICK: begin
                o_cmd.step = 1'b1;
                if (i_status.last_slot) begin
                    n_state = S_FINISH;
                end
            end
            S_QUERY: begin
                o_cmd.query = 1'b1;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/ptrt_dp.sv
`default_nettype none

module ptrt_dp #(
    parameter int unsigned NUM_TASKS = 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire ptrt_pkg::t_in_item                   i_in,
    input  wire logic                                 i_cfg_we,
    input  wire logic [ptrt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [ptrt_pkg::TIMING_W-1:0]        i_cfg_data,
    input  wire ptrt_pkg::t_cmd                       i_cmd,
    input  wire logic                                 i_out_stall,
    output ptrt_pkg::t_status                         o_status,
    output logic                                      o_out_valid,
    output ptrt_pkg::t_out_item                       o_out
);

    localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    // timing registers and task state
    logic [ptrt_pkg::TIMING_W-1:0] r_timing [NUM_TASKS];
    logic [ptrt_pkg::COUNT_W-1:0]  r_count  [NUM_TASKS];
    logic [ptrt_pkg::TICK_W-1:0]   r_last   [NUM_TASKS];
    logic [NUM_TASKS-1:0]          r_pending;
    logic [ptrt_pkg::TICK_W-1:0]   r_tick;

    // per-item working registers
    ptrt_pkg::t_in_item            r_item;
    logic [IDX_W-1:0]              r_slot;
    logic                          r_granted;
    logic                          r_out_valid;
    ptrt_pkg::t_out_item           r_out;

    // tick step on the current slot
    logic [ptrt_pkg::FIELD_W-1:0]  w_period;
    logic [ptrt_pkg::FIELD_W-1:0]  w_offset;
    logic [ptrt_pkg::COUNT_W-1:0]  w_limit;
    logic [ptrt_pkg::COUNT_W-1:0]  w_next_count;
    logic                          w_release;

    assign w_period     = r_timing[r_slot][15:0];
    assign w_offset     = r_timing[r_slot][47:32];
    assign w_limit      = ptrt_pkg::COUNT_W'(w_period) + ptrt_pkg::COUNT_W'(w_offset);
    assign w_next_count = r_count[r_slot] + ptrt_pkg::COUNT_W'(1);
    assign w_release    = (w_next_count >= w_limit);

    // query evaluation
    logic [IDX_W-1:0]              w_qidx;
    logic                          w_in_range;
    logic [ptrt_pkg::TICK_W-1:0]   w_gap;
    logic [ptrt_pkg::FIELD_W-1:0]  w_min_gap;
    logic                          w_grant;

    assign w_qidx     = r_item.task_id[IDX_W-1:0];
    assign w_in_range = (r_item.task_id < 4'(NUM_TASKS));
    assign w_gap      = r_tick - r_last[w_qidx];
    assign w_min_gap  = r_timing[w_qidx][31:16];
    assign w_grant    = w_in_range && r_pending[w_qidx]
                        && (w_gap >= ptrt_pkg::TICK_W'(w_min_gap));

    // configuration writes, beyond the task count they go nowhere
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_timing[i] <= ptrt_pkg::TIMING_RESET[i];
            end
        end else if (i_cfg_we && ({1'b0, i_cfg_idx} < 4'(NUM_TASKS))) begin
            r_timing[i_cfg_idx[IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // task state, tick count and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_count[i] <= '0;
                r_last[i]  <= '0;
            end
            r_pending   <= '0;
            r_tick      <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_slot <= '0;
                if (i_in.func == ptrt_pkg::FUNC_TICK) begin
                    r_tick <= r_tick + ptrt_pkg::TICK_W'(1);
                end
            end
            if (i_cmd.step) begin
                r_slot <= r_slot + IDX_W'(1);
                if (w_release) begin
                    r_pending[r_slot] <= 1'b1;
                    r_count[r_slot]   <= ptrt_pkg::COUNT_W'(w_offset);
                end else begin
                    r_count[r_slot]   <= w_next_count;
                end
            end
            if (i_cmd.query && w_grant) begin
                r_pending[w_qidx] <= 1'b0;
                r_last[w_qidx]    <= r_tick;
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item    <= i_in;
            r_granted <= 1'b0;
        end
        if (i_cmd.query) begin
            r_granted <= w_grant;
        end
        if (i_cmd.publish) begin
            r_out.granted      <= r_granted;
            r_out.pending_mask <= ptrt_pkg::MASK_W'(r_pending);
        end
    end

    assign o_status.last_slot = (r_slot == IDX_W'(NUM_TASKS - 1));
    assign o_status.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out              = r_out;

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int unsigned NUM_TASKS   = 8;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned PHASE_ITEMS = 320;

    // ways of picking a set of timing registers
    typedef enum int unsigned {
        CFG_SMALL,
        CFG_MIXED,
        CFG_EXTREME,
        CFG_WIDE
    } t_cfg_style;

    // receiver stall patterns
    typedef enum int unsigned {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_style;

    logic                           i_clk     = 1'b0;
    logic                           i_rst_n   = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    ptrt_pkg::t_in_item             in_item   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    ptrt_pkg::t_out_item            out_item;
    logic                           cfg_we    = 1'b0;
    logic [ptrt_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [ptrt_pkg::TIMING_W-1:0]  cfg_data  = '0;

    // timer state as the block should hold it
    logic [ptrt_pkg::TIMING_W-1:0]   timing_m   [ptrt_pkg::SLOT_COUNT];
    logic [ptrt_pkg::TICK_W-1:0]     tick_m;
    logic [ptrt_pkg::COUNT_W-1:0]    count_m    [ptrt_pkg::SLOT_COUNT];
    logic [ptrt_pkg::SLOT_COUNT-1:0] pend_m;
    logic [ptrt_pkg::TICK_W-1:0]     last_run_m [ptrt_pkg::SLOT_COUNT];

    ptrt_pkg::t_in_item  item_backlog  [$];
    ptrt_pkg::t_out_item grant_reports [$];

    int unsigned n_queued     = 0;
    int unsigned n_taken      = 0;
    int unsigned n_results    = 0;
    int unsigned n_grants     = 0;
    int unsigned n_cfg_writes = 0;
    int unsigned n_errors     = 0;
    int unsigned cycle_count  = 0;
    int unsigned burst_left   = 8;
    int unsigned gap_left     = 0;
    int unsigned stall_count  = 0;
    t_stall_style stall_style = STALL_NONE;

    periodic_task_release_timer #(
        .NUM_TASKS(NUM_TASKS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // one item through the timer: tick walks the counters, query may grant
    function automatic ptrt_pkg::t_out_item advance_timer(ptrt_pkg::t_in_item it);
        ptrt_pkg::t_out_item          r;
        logic [ptrt_pkg::COUNT_W-1:0] cnt;
        logic [ptrt_pkg::TICK_W-1:0]  lim;
        logic [ptrt_pkg::TICK_W-1:0]  gap;
        logic [ptrt_pkg::FIELD_W-1:0] per;
        logic [ptrt_pkg::FIELD_W-1:0] min_gap;
        logic [ptrt_pkg::FIELD_W-1:0] off;
        r.granted = 1'b0;
        if (it.func == ptrt_pkg::FUNC_TICK) begin
            tick_m = tick_m + 32'd1;
            for (int k = 0; k < NUM_TASKS; k++) begin
                per = timing_m[k][15:0];
                off = timing_m[k][47:32];
                lim = {16'd0, per} + {16'd0, off};
                cnt = count_m[k] + 17'd1;
                if ({15'd0, cnt} >= lim) begin
                    pend_m[k] = 1'b1;
                    cnt = {1'b0, off};
                end
                count_m[k] = cnt;
            end
        end else if (it.task_id < NUM_TASKS) begin
            min_gap = timing_m[it.task_id][31:16];
            gap = tick_m - last_run_m[it.task_id];
            if (pend_m[it.task_id] && gap >= {16'd0, min_gap}) begin
                last_run_m[it.task_id] = tick_m;
                pend_m[it.task_id] = 1'b0;
                r.granted = 1'b1;
            end
        end
        r.pending_mask = pend_m;
        return r;
    endfunction

    function automatic logic [ptrt_pkg::TIMING_W-1:0] rand_timing(t_cfg_style style,
                                                                  int unsigned slot);
        logic [ptrt_pkg::FIELD_W-1:0] per;
        logic [ptrt_pkg::FIELD_W-1:0] min_gap;
        logic [ptrt_pkg::FIELD_W-1:0] off;
        logic [63:0]                  wide;
        case (style)
            CFG_SMALL: begin
                per     = 16'($urandom_range(0, 12));
                min_gap = 16'($urandom_range(0, 6));
                off     = 16'($urandom_range(0, 8));
            end
            CFG_MIXED: begin
                per     = 16'($urandom_range(0, (slot < 4) ? 12 : 200));
                min_gap = 16'($urandom_range(0, 40));
                off     = 16'($urandom_range(0, 30));
            end
            CFG_EXTREME: begin
                per     = (slot % 2) ? '1 : '0;
                min_gap = (slot % 2) ? '1 : '0;
                off     = (slot % 2) ? '1 : '0;
            end
            default: begin
                wide = {$urandom, $urandom};
                return wide[ptrt_pkg::TIMING_W-1:0];
            end
        endcase
        return {off, min_gap, per};
    endfunction

    function automatic ptrt_pkg::t_in_item rand_item();
        ptrt_pkg::t_in_item it;
        int unsigned        pick;
        pick = $urandom_range(0, 99);
        it.func    = (pick < 55) ? ptrt_pkg::FUNC_TICK : ptrt_pkg::FUNC_QUERY;
        it.task_id = (pick < 95) ? 4'($urandom_range(0, NUM_TASKS - 1))
                                 : 4'($urandom_range(8, 15));
        return it;
    endfunction

    task automatic add_item(logic func, logic [3:0] id);
        ptrt_pkg::t_in_item it;
        it.func    = func;
        it.task_id = id;
        item_backlog.push_back(it);
        n_queued++;
    endtask

    task automatic write_timing(int unsigned idx, logic [ptrt_pkg::TIMING_W-1:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx[ptrt_pkg::CFG_IDX_W-1:0];
        cfg_data <= value;
        timing_m[idx] = value;
        n_cfg_writes++;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // all items taken and all results back, then let the block settle
    task automatic wait_idle();
        while (n_taken != n_queued || grant_reports.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic flag_error(string msg);
        if (n_errors < 10) $display("%s", msg);
        n_errors++;
    endtask

    // driver: bursts of items with random gaps between them
    always @(posedge i_clk) begin : drive
        logic               next_valid;
        ptrt_pkg::t_in_item next_item;
        next_valid = in_valid;
        next_item  = in_item;
        if (i_rst_n) begin
            if (in_valid && !in_stall) begin
                grant_reports.push_back(advance_timer(in_item));
                n_taken++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (item_backlog.size() != 0) begin
                    next_item  = item_backlog.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
        end
        in_valid <= next_valid;
        in_item  <= next_item;
    end

    // monitor: compare each result item with the oldest prediction
    always @(posedge i_clk) begin : check
        ptrt_pkg::t_out_item want;
        logic                next_stall;
        if (i_rst_n && out_valid && !out_stall) begin
            n_results++;
            if (out_item.granted) n_grants++;
            if (grant_reports.size() == 0) begin
                flag_error($sformatf("unexpected result: granted %0b mask %02h",
                                     out_item.granted, out_item.pending_mask));
            end else begin
                want = grant_reports.pop_front();
                if (out_item.granted !== want.granted ||
                    out_item.pending_mask !== want.pending_mask) begin
                    flag_error($sformatf(
                        "mismatch at result %0d: granted exp %0b got %0b, mask exp %02h got %02h",
                        n_results, want.granted, out_item.granted,
                        want.pending_mask, out_item.pending_mask));
                end
            end
        end
        // receiver stall pattern, drawn at random from the four styles
        stall_count++;
        if (stall_count % 256 == 0) stall_style = t_stall_style'($urandom_range(0, 3));
        case (stall_style)
            STALL_LIGHT:    next_stall = ($urandom_range(0, 9) < 3);
            STALL_HEAVY:    next_stall = ($urandom_range(0, 9) < 7);
            STALL_PERIODIC: next_stall = ((stall_count % 7) < 3);
            default:        next_stall = 1'b0;
        endcase
        out_stall <= i_rst_n ? next_stall : 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, grant_reports.size());
            $display("tb: errors");
            $finish;
        end
    end

    initial begin : stimulus
        t_cfg_style styles [6];
        styles = '{CFG_SMALL, CFG_MIXED, CFG_EXTREME, CFG_SMALL, CFG_WIDE, CFG_SMALL};
        timing_m = ptrt_pkg::TIMING_RESET;
        tick_m   = '0;
        pend_m   = '0;
        for (int k = 0; k < ptrt_pkg::SLOT_COUNT; k++) begin
            count_m[k]    = '0;
            last_run_m[k] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset timing: task 0 releases after two ticks, ids out of range refused
        add_item(ptrt_pkg::FUNC_TICK, 4'd0);
        add_item(ptrt_pkg::FUNC_TICK, 4'd0);
        add_item(ptrt_pkg::FUNC_QUERY, 4'd0);
        add_item(ptrt_pkg::FUNC_QUERY, 4'd7);
        add_item(ptrt_pkg::FUNC_QUERY, 4'd8);
        add_item(ptrt_pkg::FUNC_QUERY, 4'd15);
        wait_idle();

        // zero period and offset, all-ones fields, a long period on task 2
        write_timing(0, '0);
        write_timing(1, '1);
        write_timing(2, {16'd0, 16'd0, 16'd40});
        for (int k = 3; k < ptrt_pkg::SLOT_COUNT; k++) write_timing(k, rand_timing(CFG_SMALL, k));
        repeat (4) add_item(ptrt_pkg::FUNC_TICK, 4'd0);
        add_item(ptrt_pkg::FUNC_QUERY, 4'd0);
        add_item(ptrt_pkg::FUNC_QUERY, 4'd0);
        add_item(ptrt_pkg::FUNC_QUERY, 4'd1);
        add_item(ptrt_pkg::FUNC_QUERY, 4'd2);
        wait_idle();

        // task 2 threshold dropped under its running counter, task 4 held by min interval
        write_timing(2, {16'd0, 16'd0, 16'd1});
        write_timing(4, {16'd0, 16'd5, 16'd0});
        add_item(ptrt_pkg::FUNC_TICK, 4'd0);
        add_item(ptrt_pkg::FUNC_QUERY, 4'd2);
        add_item(ptrt_pkg::FUNC_QUERY, 4'd4);
        add_item(ptrt_pkg::FUNC_TICK, 4'd0);
        add_item(ptrt_pkg::FUNC_QUERY, 4'd4);
        add_item(ptrt_pkg::FUNC_QUERY, 4'd9);
        wait_idle();

        // random phases, each under fresh timing
        foreach (styles[p]) begin
            for (int k = 0; k < ptrt_pkg::SLOT_COUNT; k++) begin
                write_timing(k, rand_timing(styles[p], k));
            end
            repeat (PHASE_ITEMS) begin
                item_backlog.push_back(rand_item());
                n_queued++;
            end
            wait_idle();
        end

        if (grant_reports.size() != 0)
            flag_error($sformatf("%0d results never arrived", grant_reports.size()));
        $display("run covered %0d items under %0d register writes: %0d results, %0d grants",
                 n_taken, n_cfg_writes, n_results, n_grants);
        $display("%0d mismatches over %0d cycles", n_errors, cycle_count);
        if (n_errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/ptrt_pkg.sv
rtl/core/ptrt_ctrl.sv
rtl/core/ptrt_dp.sv
rtl/core/periodic_task_release_timer.sv
dv/tb.sv
